// ===== rtl/core/dmp_pkg.sv =====
// shared types, sizes and codes for the dependency mask propagator
// no dependencies; compiled before every other file of the block
package dmp_pkg;

    localparam int WORK_DEPTH   = 1024;
    localparam int MASK_WIDTH   = 64;
    localparam int ADDR_W       = $clog2(WORK_DEPTH);
    localparam int SLOT_W       = 10;
    localparam int EXT_W        = 64;
    localparam int OP_W         = 3;
    // entries carry an epoch tag; a clear bumps the live epoch
    localparam int EPOCH_W      = 8;
    localparam int ENTRY_W      = EPOCH_W + MASK_WIDTH;
    localparam int SLOT_EXT_W   = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
    localparam int SLOT_RANGE_W = SLOT_EXT_W + 1;

    typedef logic [OP_W-1:0]       op_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [MASK_WIDTH-1:0] mask_t;
    typedef logic [EXT_W-1:0]      ext_t;
    typedef logic [EPOCH_W-1:0]    epoch_t;
    typedef logic [1:0]            sel_t;
    typedef logic [1:0]            wsrc_t;

    localparam op_t OP_CLEAR = 3'd0;
    localparam op_t OP_PARAM = 3'd1;
    localparam op_t OP_ARG   = 3'd2;
    localparam op_t OP_RES   = 3'd3;
    localparam op_t OP_OPER  = 3'd4;

    // slot address selects
    localparam sel_t SEL_DST   = 2'd0;
    localparam sel_t SEL_SRC_A = 2'd1;
    localparam sel_t SEL_SRC_B = 2'd2;

    // write data sources
    localparam wsrc_t WSRC_ZERO   = 2'd0;
    localparam wsrc_t WSRC_EXT    = 2'd1;
    localparam wsrc_t WSRC_OR_ACC = 2'd2;
    localparam wsrc_t WSRC_OR_EXT = 2'd3;

    typedef struct packed {
        logic  load;
        logic  rd_en;
        sel_t  rd_sel;
        logic  wr_en;
        sel_t  wr_sel;
        wsrc_t wr_src;
        logic  acc_ld;
        logic  out_ld;
        logic  out_kind;
        logic  epoch_inc;
        logic  sweep_wr;
        logic  sweep_done;
    } dmp_cmd_t;

    typedef struct packed {
        logic epoch_max;
        logic sweep_last;
        logic out_full;
    } dmp_stat_t;

endpackage

// ===== rtl/core/dmp_if.sv =====
// valid/ready channel interfaces for instruction beats and result beats
// depends on dmp_pkg for field types
interface dmp_item_if;
    logic             valid;
    logic             ready;
    dmp_pkg::op_t     op;
    dmp_pkg::slot_t   dest_slot;
    dmp_pkg::slot_t   src_a_slot;
    dmp_pkg::slot_t   src_b_slot;
    dmp_pkg::ext_t    ext_mask;
    logic             ext_present;

    modport source (output valid, output op, output dest_slot, output src_a_slot,
                    output src_b_slot, output ext_mask, output ext_present, input ready);
    modport sink   (input valid, input op, input dest_slot, input src_a_slot,
                    input src_b_slot, input ext_mask, input ext_present, output ready);
endinterface

interface dmp_result_if;
    logic          valid;
    logic          ready;
    dmp_pkg::ext_t out_mask;
    logic          out_kind;

    modport source (output valid, output out_mask, output out_kind, input ready);
    modport sink   (input valid, input out_mask, input out_kind, output ready);
endinterface

// ===== rtl/core/dmp_ram.sv =====
// generic simple dual port ram: one write port, one registered read port
// no dependencies
module dmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dmp_dpath.sv =====
// datapath: item latch, mask store with epoch tags, bypass, accumulator, result register
// depends on dmp_pkg and dmp_ram
module dmp_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  dmp_pkg::dmp_cmd_t  cmd,
    output dmp_pkg::dmp_stat_t st,
    input  dmp_pkg::slot_t     dest_slot,
    input  dmp_pkg::slot_t     src_a_slot,
    input  dmp_pkg::slot_t     src_b_slot,
    input  dmp_pkg::ext_t      ext_mask,
    input  logic               ext_present,
    input  logic               out_ready,
    output logic               out_valid,
    output dmp_pkg::ext_t      out_mask,
    output logic               out_kind
);
    import dmp_pkg::*;

    slot_t  dst_reg;
    slot_t  sa_reg;
    slot_t  sb_reg;
    mask_t  ext_reg;
    logic   pres_reg;
    mask_t  acc_reg;
    epoch_t epoch_reg;
    addr_t  sweep_cnt_reg;
    logic   rd_range_reg;
    logic   byp_hit_reg;
    mask_t  byp_data_reg;
    logic   out_valid_reg;
    ext_t   out_mask_reg;
    logic   out_kind_reg;

    slot_t               rd_slot;
    slot_t               wr_slot;
    logic                rd_ok;
    logic                wr_ok;
    mask_t               rd_mask;
    mask_t               wr_mask;
    logic                ram_we;
    addr_t               ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    epoch_t              rd_tag;

    function automatic logic in_range(input slot_t s);
        logic [SLOT_RANGE_W-1:0] v;
        v = SLOT_RANGE_W'(s);
        return v < SLOT_RANGE_W'(WORK_DEPTH);
    endfunction

    function automatic addr_t to_addr(input slot_t s);
        logic [SLOT_EXT_W-1:0] v;
        v = SLOT_EXT_W'(s);
        return v[ADDR_W-1:0];
    endfunction

    function automatic slot_t pick_slot(input sel_t sel, input slot_t d, input slot_t a,
                                        input slot_t b);
        slot_t s;
        case (sel)
            SEL_DST:   s = d;
            SEL_SRC_A: s = a;
            SEL_SRC_B: s = b;
            default:   s = d;
        endcase
        return s;
    endfunction

    assign rd_slot = pick_slot(cmd.rd_sel, dst_reg, sa_reg, sb_reg);
    assign wr_slot = pick_slot(cmd.wr_sel, dst_reg, sa_reg, sb_reg);
    assign rd_ok   = in_range(rd_slot);
    assign wr_ok   = cmd.wr_en && in_range(wr_slot);

    // stale epoch, out-of-range slot or same-cycle write all resolved here
    assign rd_tag  = ram_rdata[ENTRY_W-1 -: EPOCH_W];
    always_comb
    begin
        if (!rd_range_reg)
        begin
            rd_mask = '0;
        end
        else if (byp_hit_reg)
        begin
            rd_mask = byp_data_reg;
        end
        else if (rd_tag == epoch_reg)
        begin
            rd_mask = ram_rdata[MASK_WIDTH-1:0];
        end
        else
        begin
            rd_mask = '0;
        end
    end

    always_comb
    begin
        case (cmd.wr_src)
            WSRC_ZERO:   wr_mask = '0;
            WSRC_EXT:    wr_mask = pres_reg ? ext_reg : '0;
            WSRC_OR_ACC: wr_mask = rd_mask | acc_reg;
            WSRC_OR_EXT: wr_mask = rd_mask | ext_reg;
            default:     wr_mask = '0;
        endcase
    end

    assign ram_we    = wr_ok || cmd.sweep_wr;
    assign ram_waddr = cmd.sweep_wr ? sweep_cnt_reg : to_addr(wr_slot);
    assign ram_wdata = cmd.sweep_wr ? '0 : {epoch_reg, wr_mask};

    dmp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WORK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (to_addr(rd_slot)),
        .rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dst_reg  <= dest_slot;
            sa_reg   <= src_a_slot;
            sb_reg   <= src_b_slot;
            ext_reg  <= ext_mask[MASK_WIDTH-1:0];
            pres_reg <= ext_present;
        end
        if (cmd.acc_ld)
        begin
            acc_reg <= rd_mask;
        end
        if (cmd.out_ld)
        begin
            out_mask_reg <= EXT_W'(acc_reg);
            out_kind_reg <= cmd.out_kind;
        end
        rd_range_reg <= rd_ok;
        byp_data_reg <= wr_mask;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= EPOCH_W'(1);
            sweep_cnt_reg <= '0;
            byp_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_done)
            begin
                epoch_reg <= EPOCH_W'(1);
            end
            else if (cmd.epoch_inc)
            begin
                epoch_reg <= epoch_reg + EPOCH_W'(1);
            end
            if (cmd.sweep_done)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.sweep_wr)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
            end
            byp_hit_reg <= cmd.rd_en && wr_ok && (wr_slot == rd_slot);
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.epoch_max  = &epoch_reg;
    assign st.sweep_last = (sweep_cnt_reg == ADDR_W'(WORK_DEPTH - 1));
    assign st.out_full   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_mask  = out_mask_reg;
    assign out_kind  = out_kind_reg;

endmodule

// ===== rtl/core/dmp_ctrl.sv =====
// controller: direction register and the sequencer that steps each instruction
// depends on dmp_pkg
module dmp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               item_valid,
    input  dmp_pkg::op_t       item_op,
    input  logic               item_present,
    output logic               item_ready,
    input  logic               out_ready,
    input  dmp_pkg::dmp_stat_t st,
    output dmp_pkg::dmp_cmd_t  cmd
);
    import dmp_pkg::*;

    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_WR_D    = 4'd2;
    localparam logic [3:0] S_RD_A    = 4'd3;
    localparam logic [3:0] S_RD_B    = 4'd4;
    localparam logic [3:0] S_FW_WR   = 4'd5;
    localparam logic [3:0] S_RD_D    = 4'd6;
    localparam logic [3:0] S_SEED    = 4'd7;
    localparam logic [3:0] S_ADJ_A   = 4'd8;
    localparam logic [3:0] S_ADJ_B   = 4'd9;
    localparam logic [3:0] S_OUT_CAP = 4'd10;
    localparam logic [3:0] S_IN_CLR  = 4'd11;
    localparam logic [3:0] S_ADJ_OUT = 4'd12;
    localparam logic [3:0] S_EMIT    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       dir_reg;
    op_t        op_reg;
    logic       pres_reg;
    logic       accept;

    function automatic logic [3:0] first_state(input op_t op, input logic pres,
                                               input logic dir);
        logic [3:0] s;
        unique case (op)
            OP_PARAM: s = S_WR_D;
            OP_ARG:   s = dir ? S_RD_D : S_WR_D;
            OP_RES:   s = pres ? S_RD_A : S_IDLE;
            OP_OPER:  s = dir ? S_RD_D : S_RD_A;
            default:  s = S_IDLE;
        endcase
        return s;
    endfunction

    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = dir_reg;
        state_next   = state_reg;
        item_ready   = 1'b0;
        unique case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (st.sweep_last)
                begin
                    cmd.sweep_done = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
            end
            S_WR_D:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_DST;
                cmd.wr_src = (op_reg == OP_ARG) ? WSRC_EXT : WSRC_ZERO;
                item_ready = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_SRC_A;
                if (dir_reg)
                begin
                    state_next = S_ADJ_OUT;
                end
                else if (op_reg == OP_OPER)
                begin
                    state_next = S_RD_B;
                end
                else
                begin
                    state_next = S_OUT_CAP;
                end
            end
            S_RD_B:
            begin
                cmd.acc_ld = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_SRC_B;
                state_next = S_FW_WR;
            end
            S_FW_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_DST;
                cmd.wr_src = WSRC_OR_ACC;
                item_ready = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_D:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_DST;
                state_next = (op_reg == OP_OPER) ? S_SEED : S_IN_CLR;
            end
            S_SEED:
            begin
                cmd.acc_ld = 1'b1;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_DST;
                cmd.wr_src = WSRC_ZERO;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_SRC_A;
                state_next = S_ADJ_A;
            end
            S_ADJ_A:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_SRC_A;
                cmd.wr_src = WSRC_OR_ACC;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_SRC_B;
                state_next = S_ADJ_B;
            end
            S_ADJ_B:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_SRC_B;
                cmd.wr_src = WSRC_OR_ACC;
                item_ready = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT_CAP:
            begin
                cmd.acc_ld = 1'b1;
                state_next = S_EMIT;
            end
            S_IN_CLR:
            begin
                cmd.acc_ld = 1'b1;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_DST;
                cmd.wr_src = WSRC_ZERO;
                state_next = pres_reg ? S_EMIT : S_IDLE;
            end
            S_ADJ_OUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_SRC_A;
                cmd.wr_src = WSRC_OR_EXT;
                item_ready = 1'b1;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!st.out_full || out_ready)
                begin
                    cmd.out_ld = 1'b1;
                    item_ready = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        accept = item_valid && item_ready;
        if (accept)
        begin
            cmd.load   = 1'b1;
            state_next = first_state(item_op, item_present, dir_reg);
            // clear: bump the epoch, or sweep the store when the tags run out
            if (item_op == OP_CLEAR)
            begin
                if (st.epoch_max)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    cmd.epoch_inc = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            dir_reg   <= 1'b0;
            op_reg    <= OP_CLEAR;
            pres_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                dir_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                op_reg   <= item_op;
                pres_reg <= item_present;
            end
        end
    end

`ifndef ASSERT_OFF
    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && st.sweep_last) |=> (state_reg == S_IDLE))
        else $error("sweep did not return to idle after the last entry");

    a_wrap_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_op == OP_CLEAR && st.epoch_max) |=> (state_reg == S_SWEEP))
        else $error("epoch wrap did not start a store sweep");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> (!st.out_full || out_ready))
        else $error("result register overwritten while still held");
`endif

endmodule

// ===== rtl/core/dependency_mask_propagator_top.sv =====
// top level of the dependency mask propagator: channels, config port, controller, datapath
// depends on dmp_pkg, dmp_if, dmp_ctrl and dmp_dpath
//
// per instruction: clear with no sweep, unused op, or output with no vector: accept only;
//   constant and forward input: WR_D; forward op: RD_A, RD_B, FW_WR; adjoint op: RD_D,
//   SEED, ADJ_A, ADJ_B; adjoint output: RD_A, ADJ_OUT; forward output: RD_A, OUT_CAP,
//   EMIT; adjoint input: RD_D, IN_CLR, EMIT with a vector; EMIT waits while a result is
//   held; one store read port sets the pace; reset (async, active low) starts a tag sweep
//   over the store with no beats accepted; every 255th clear repeats that sweep
module dependency_mask_propagator_top (
    input  logic        clk,
    input  logic        rst_n,
    dmp_item_if.sink    items,
    dmp_result_if.source results,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import dmp_pkg::*;

    // command and status between sequencer and datapath
    dmp_cmd_t  cmd;
    dmp_stat_t st;
    logic      item_ready;

    // sequencer: one state per step; WR_D, FW_WR, ADJ_B, ADJ_OUT and EMIT take the next beat
    dmp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (items.valid),
        .item_op      (items.op),
        .item_present (items.ext_present),
        .item_ready   (item_ready),
        .out_ready    (results.ready),
        .st           (st),
        .cmd          (cmd)
    );

    // store, epoch tags, same-cycle write bypass and the result register
    dmp_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .dest_slot   (items.dest_slot),
        .src_a_slot  (items.src_a_slot),
        .src_b_slot  (items.src_b_slot),
        .ext_mask    (items.ext_mask),
        .ext_present (items.ext_present),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .out_mask    (results.out_mask),
        .out_kind    (results.out_kind)
    );

    // beat is taken when the sequencer can start a new instruction
    assign items.ready = item_ready;

endmodule
